// ===== rtl/acfcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acfcc_pkg
// Shared types, character codes and CRC helper for the ASCII command frame
// CRC checker.
// ----------------------------------------------------------------------------
package acfcc_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 63;
  localparam int N_FIELDS            = 4;
  localparam int FIELD_W             = 16;
  localparam int REF_W               = 24;
  localparam int TOK_W               = 3;

  localparam logic [7:0] CRC_POLY     = 8'h8C;
  localparam logic [7:0] CRC_INIT     = 8'h00;
  localparam logic [7:0] TRACK_RESET  = 8'd24;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_START     = 8'h24;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_END       = 8'h3B;

  localparam logic [15:0] MAG_SAT     = 16'd32768;
  localparam logic [15:0] POS_MAX     = 16'd32767;
  localparam logic [TOK_W-1:0] TOK_MAX = TOK_W'(N_FIELDS);

  typedef logic [FIELD_W-1:0] field_t;

  // Frame summary handed from the parser to the reference pipeline
  typedef struct packed {
    field_t [N_FIELDS-1:0] fields;
    logic [7:0]            crc;
    logic [TOK_W-1:0]      tok;
  } frame_sum_t;

  // Reflected CRC-8, one byte, LSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] c;
    logic       mix;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      mix = c[0] ^ b[k];
      c   = {1'b0, c[7:1]};
      if (mix) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // atoi-style token value from sign and saturated magnitude
  function automatic field_t token_value(input logic neg, input logic [15:0] mag);
    field_t v;
    if (neg) begin
      v = 16'd0 - mag;
    end else if (mag > POS_MAX) begin
      v = POS_MAX;
    end else begin
      v = mag;
    end
    return v;
  endfunction

endpackage

// ===== rtl/acfcc_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acfcc_parser
// Byte-level frame parser: tokenizes, converts fields, runs the CRC and
// flags the end of each non-empty frame with a summary.
// ----------------------------------------------------------------------------
module acfcc_parser import acfcc_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_accept,
  input  logic [7:0] rx_byte,
  output logic       fin_valid,
  output frame_sum_t fin_sum
);

  localparam int CntW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_FRAME_BYTES);

  logic             in_frame_r, in_frame_nxt;
  logic [CntW-1:0]  byte_count_r, byte_count_nxt;
  logic [TOK_W-1:0] token_index_r, token_index_nxt;
  logic             inside_token_r, inside_token_nxt;
  logic             digits_done_r, digits_done_nxt;
  logic             negative_sign_r, negative_sign_nxt;
  logic             sign_seen_r, sign_seen_nxt;
  logic             text_ended_r, text_ended_nxt;
  logic [15:0]      number_accum_r, number_accum_nxt;
  logic [7:0]       crc_r, crc_nxt;
  field_t [N_FIELDS-1:0] held_r, held_nxt;
  logic             fin;

  always_comb begin
    logic        skip;
    logic        handled;
    logic [19:0] acc_wide;
    in_frame_nxt      = in_frame_r;
    byte_count_nxt    = byte_count_r;
    token_index_nxt   = token_index_r;
    inside_token_nxt  = inside_token_r;
    digits_done_nxt   = digits_done_r;
    negative_sign_nxt = negative_sign_r;
    sign_seen_nxt     = sign_seen_r;
    text_ended_nxt    = text_ended_r;
    number_accum_nxt  = number_accum_r;
    crc_nxt           = crc_r;
    held_nxt          = held_r;
    fin               = 1'b0;
    skip              = 1'b0;
    handled           = 1'b0;
    acc_wide          = '0;
    if (byte_accept) begin
      if (!in_frame_r) begin
        if (rx_byte == CH_START) begin
          in_frame_nxt      = 1'b1;
          byte_count_nxt    = '0;
          token_index_nxt   = '0;
          inside_token_nxt  = 1'b0;
          digits_done_nxt   = 1'b0;
          negative_sign_nxt = 1'b0;
          sign_seen_nxt     = 1'b0;
          number_accum_nxt  = '0;
          crc_nxt           = CRC_INIT;
          text_ended_nxt    = 1'b0;
        end
      end else if (rx_byte == CH_END) begin
        if (byte_count_r == '0) begin
          in_frame_nxt = 1'b0;
        end else begin
          fin = 1'b1;
        end
      end else begin
        byte_count_nxt = byte_count_r + 1'b1;
        if (!text_ended_r) begin
          if (rx_byte == CH_NUL || rx_byte == CH_SPACE) begin
            if (inside_token_r) begin
              if (token_index_r < TOK_MAX) begin
                held_nxt[token_index_r[1:0]] = token_value(negative_sign_r, number_accum_r);
                token_index_nxt = token_index_r + 1'b1;
              end
              inside_token_nxt = 1'b0;
            end
            if (rx_byte == CH_NUL) begin
              text_ended_nxt = 1'b1;
            end
          end else begin
            if (!inside_token_r) begin
              if (token_index_r >= TOK_MAX) begin
                skip = 1'b1;
              end else begin
                inside_token_nxt  = 1'b1;
                digits_done_nxt   = 1'b0;
                negative_sign_nxt = 1'b0;
                sign_seen_nxt     = 1'b0;
                number_accum_nxt  = '0;
                if (token_index_r == '0) begin
                  crc_nxt = crc8_byte(crc_nxt, CH_START);
                end else if (token_index_r < TOK_W'(3)) begin
                  crc_nxt = crc8_byte(crc_nxt, CH_SPACE);
                end
              end
            end
            if (!skip) begin
              if (token_index_r < TOK_W'(3)) begin
                crc_nxt = crc8_byte(crc_nxt, rx_byte);
              end
              if (!digits_done_nxt) begin
                if (!sign_seen_nxt) begin
                  if (rx_byte >= CH_TAB && rx_byte <= CH_CR) begin
                    handled = 1'b1;
                  end else begin
                    sign_seen_nxt = 1'b1;
                    if (rx_byte == CH_PLUS) begin
                      handled = 1'b1;
                    end else if (rx_byte == CH_MINUS) begin
                      negative_sign_nxt = 1'b1;
                      handled           = 1'b1;
                    end
                  end
                end
                if (!handled) begin
                  if (rx_byte >= CH_ZERO && rx_byte <= CH_NINE) begin
                    // acc*10 = acc*8 + acc*2, then clamp at the negative limit
                    acc_wide = {1'b0, number_accum_nxt, 3'b000}
                             + {3'b000, number_accum_nxt, 1'b0}
                             + {16'd0, rx_byte[3:0]};
                    number_accum_nxt = (acc_wide > {4'd0, MAG_SAT}) ? MAG_SAT
                                                                     : acc_wide[15:0];
                  end else begin
                    digits_done_nxt = 1'b1;
                  end
                end
              end
            end
          end
        end
        if (byte_count_nxt >= CntMax) begin
          fin = 1'b1;
        end
      end
      if (fin) begin
        if (inside_token_nxt) begin
          if (token_index_nxt < TOK_MAX) begin
            held_nxt[token_index_nxt[1:0]] = token_value(negative_sign_nxt, number_accum_nxt);
            token_index_nxt = token_index_nxt + 1'b1;
          end
          inside_token_nxt = 1'b0;
        end
        in_frame_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r      <= 1'b0;
      byte_count_r    <= '0;
      token_index_r   <= '0;
      inside_token_r  <= 1'b0;
      digits_done_r   <= 1'b0;
      negative_sign_r <= 1'b0;
      sign_seen_r     <= 1'b0;
      text_ended_r    <= 1'b0;
      number_accum_r  <= '0;
      crc_r           <= CRC_INIT;
      held_r          <= '0;
    end else begin
      in_frame_r      <= in_frame_nxt;
      byte_count_r    <= byte_count_nxt;
      token_index_r   <= token_index_nxt;
      inside_token_r  <= inside_token_nxt;
      digits_done_r   <= digits_done_nxt;
      negative_sign_r <= negative_sign_nxt;
      sign_seen_r     <= sign_seen_nxt;
      text_ended_r    <= text_ended_nxt;
      number_accum_r  <= number_accum_nxt;
      crc_r           <= crc_nxt;
      held_r          <= held_nxt;
    end
  end

  assign fin_valid      = fin;
  assign fin_sum.fields = held_nxt;
  assign fin_sum.crc    = crc_nxt;
  assign fin_sum.tok    = token_index_nxt;

endmodule

// ===== rtl/ascii_command_frame_crc_checker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_command_frame_crc_checker_top
// Parses '$'-framed ASCII commands, checks their CRC-8 and keeps the wheel
// references.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_rx_byte): one received byte per
//   beat. Bytes outside a frame other than '$' are dropped silently.
//   Result channel (out_valid / out_stall / out_*): one beat per non-empty
//   frame, issued on ';' or when the frame reaches MAX_FRAME_BYTES bytes.
//   Config channel (cfg_valid / cfg_ready / cfg_track_factor): always ready;
//   write only while no frame result is outstanding.
// Throughput: one byte per cycle while in_stall is low. The parser updates its
//   state in the cycle the byte is taken; the frame summary then goes through
//   a summary register, a multiply register (turn * track_factor) and the
//   output register before it appears on the result channel.
// Stall: the three result stages form a stall-propagating pipeline; in_stall
//   rises only when the summary stage is full and cannot move on.
// Reset (rst_n low, synchronous): parser idle, held fields and wheel
//   references zero, track_factor 24, no result pending.
// ----------------------------------------------------------------------------
module ascii_command_frame_crc_checker_top import acfcc_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_rx_byte,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [15:0]      out_speed_cmd,
  output logic signed [15:0]      out_turn_cmd,
  output logic signed [15:0]      out_sense_cmd,
  output logic signed [15:0]      out_crc_received,
  output logic [7:0]              out_crc_computed,
  output logic                    out_crc_ok,
  output logic signed [REF_W-1:0] out_left_ref,
  output logic signed [REF_W-1:0] out_right_ref,
  output logic [TOK_W-1:0]        out_token_total,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [7:0]              cfg_track_factor
);

  logic       cfg_wr;
  logic [7:0] track_r;

  logic       byte_accept;
  logic       fin_valid;
  frame_sum_t fin_sum;

  logic       b_valid_r;
  frame_sum_t b_sum_r;
  logic       p_valid_r;
  frame_sum_t p_sum_r;
  logic       p_ok_r;
  logic signed [24:0] p_prod_r;
  logic       o_valid_r;
  frame_sum_t o_sum_r;
  logic       o_ok_r;
  logic [REF_W-1:0] left_r, right_r;

  logic o_ready, p_ready, b_ready;
  logic b_ok;
  logic signed [25:0] spd2, prod_x, dl, dr, lt, rt;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r <= TRACK_RESET;
    end else if (cfg_wr) begin
      track_r <= cfg_track_factor;
    end
  end

  assign o_ready     = !o_valid_r || !out_stall;
  assign p_ready     = !p_valid_r || o_ready;
  assign b_ready     = !b_valid_r || p_ready;
  assign in_stall    = !b_ready;
  assign byte_accept = in_valid && !in_stall;

  acfcc_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_accept(byte_accept),
    .rx_byte    (in_rx_byte),
    .fin_valid  (fin_valid),
    .fin_sum    (fin_sum)
  );

  // received CRC must lie in 0..255 and match
  assign b_ok = (b_sum_r.fields[3][15:8] == 8'd0) && (b_sum_r.fields[3][7:0] == b_sum_r.crc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      p_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (b_ready) begin
        b_valid_r <= fin_valid;
      end
      if (p_ready) begin
        p_valid_r <= b_valid_r;
      end
      if (o_ready) begin
        o_valid_r <= p_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && fin_valid) begin
      b_sum_r <= fin_sum;
    end
    if (p_ready && b_valid_r) begin
      p_sum_r  <= b_sum_r;
      p_ok_r   <= b_ok;
      p_prod_r <= $signed(b_sum_r.fields[1]) * $signed({1'b0, track_r});
    end
    if (o_ready && p_valid_r) begin
      o_sum_r <= p_sum_r;
      o_ok_r  <= p_ok_r;
    end
  end

  // (2*speed -/+ diff) / 2, rounded toward zero
  always_comb begin
    spd2   = {{9{p_sum_r.fields[0][15]}}, p_sum_r.fields[0], 1'b0};
    prod_x = {p_prod_r[24], p_prod_r};
    dl     = spd2 - prod_x;
    dr     = spd2 + prod_x;
    lt     = dl + {25'd0, dl[25]};
    rt     = dr + {25'd0, dr[25]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      right_r <= '0;
    end else if (o_ready && p_valid_r && p_ok_r) begin
      left_r  <= lt[REF_W:1];
      right_r <= rt[REF_W:1];
    end
  end

  assign out_valid        = o_valid_r;
  assign out_speed_cmd    = o_sum_r.fields[0];
  assign out_turn_cmd     = o_sum_r.fields[1];
  assign out_sense_cmd    = o_sum_r.fields[2];
  assign out_crc_received = o_sum_r.fields[3];
  assign out_crc_computed = o_sum_r.crc;
  assign out_crc_ok       = o_ok_r;
  assign out_left_ref     = left_r;
  assign out_right_ref    = right_r;
  assign out_token_total  = o_sum_r.tok;

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (b_valid_r && p_valid_r && o_valid_r && out_stall))
    else $error("input stalled with room in the result pipeline");

  a_refs_hold_on_bad_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (o_ready && p_valid_r && !p_ok_r) |=> ($stable(left_r) && $stable(right_r)))
    else $error("wheel references changed on a failed CRC");

  a_ok_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (p_ready && b_valid_r) |=> (p_ok_r == ((p_sum_r.fields[3][15:8] == 8'd0)
                                 && (p_sum_r.fields[3][7:0] == p_sum_r.crc))))
    else $error("crc_ok disagrees with the frame summary");

  a_token_bound: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r |-> (o_sum_r.tok <= TOK_MAX))
    else $error("token count beyond four");

  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && out_stall) |=> (o_valid_r && $stable(o_sum_r) && $stable(left_r)))
    else $error("stalled result lost or changed");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ASCII command frame CRC checker. Byte streams
// are mostly well-formed '$' frames with good or bad CRC tokens, plus noise,
// garbage and overlong frames. A scoreboard tracks the parser, held fields
// and wheel references, and compares each result beat in order. Both
// channels idle and stall at random, and track_factor changes between
// phases.
// ----------------------------------------------------------------------------
module tb_top import acfcc_pkg::*; ();

  typedef struct {
    logic signed [15:0] speed;
    logic signed [15:0] turn;
    logic signed [15:0] sense;
    logic signed [15:0] crc_rx;
    logic [7:0]         crc_calc;
    logic               ok;
    logic signed [23:0] left;
    logic signed [23:0] right;
    logic [2:0]         tokens;
  } cmd_result_t;

  // Reflected CRC-8, one byte
  function automatic bit [7:0] crc8_next(bit [7:0] acc, bit [7:0] data);
    bit [7:0] r;
    r = acc ^ data;
    for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic bit [7:0] crc_text(string s);
    bit [7:0] c;
    c = CRC_INIT;
    for (int i = 0; i < s.len(); i++) c = crc8_next(c, s[i]);
    return c;
  endfunction

  class cmd_frame_scoreboard;
    bit [7:0]    factor = TRACK_RESET;
    bit          active, in_tok, conv_done, neg, sign_seen, text_end;
    int unsigned nbytes, tok_idx, mag;
    bit [7:0]    crc;
    bit [15:0]   held[4] = '{default: 0};
    bit [23:0]   refs[2] = '{default: 0};
    cmd_result_t wanted[$];
    int          errors;

    function void put_token();
      bit [15:0] v;
      if (neg) v = 16'(0 - mag);
      else v = (mag > 32767) ? 16'd32767 : 16'(mag);
      if (tok_idx < 4) begin
        held[tok_idx] = v;
        tok_idx++;
      end
      in_tok = 0;
    endfunction

    function void text_char(bit [7:0] b);
      if (text_end) return;
      if (b == CH_NUL || b == CH_SPACE) begin
        if (in_tok) put_token();
        if (b == CH_NUL) text_end = 1;
        return;
      end
      if (!in_tok) begin
        if (tok_idx >= 4) return;
        in_tok = 1;
        conv_done = 0;
        neg = 0;
        sign_seen = 0;
        mag = 0;
        if (tok_idx == 0) crc = crc8_next(crc, CH_START);
        else if (tok_idx < 3) crc = crc8_next(crc, CH_SPACE);
      end
      // only the first three tokens go into the CRC text
      if (tok_idx < 3) crc = crc8_next(crc, b);
      if (conv_done) return;
      if (!sign_seen) begin
        if (b >= CH_TAB && b <= CH_CR) return;
        sign_seen = 1;
        if (b == CH_PLUS) return;
        if (b == CH_MINUS) begin
          neg = 1;
          return;
        end
      end
      if (b >= CH_ZERO && b <= CH_NINE) begin
        mag = mag * 10 + (b - CH_ZERO);
        if (mag > 32768) mag = 32768;
      end else begin
        conv_done = 1;
      end
    endfunction

    function void close_frame();
      cmd_result_t r;
      int spd, trn, diff;
      bit good;
      if (in_tok) put_token();
      active = 0;
      good = (held[3][15:8] == 8'd0) && (held[3][7:0] == crc);
      if (good) begin
        spd = $signed(held[0]);
        trn = $signed(held[1]);
        diff = trn * int'(factor);
        refs[0] = 24'((2 * spd - diff) / 2);
        refs[1] = 24'((2 * spd + diff) / 2);
      end
      r.speed    = held[0];
      r.turn     = held[1];
      r.sense    = held[2];
      r.crc_rx   = held[3];
      r.crc_calc = crc;
      r.ok       = good;
      r.left     = refs[0];
      r.right    = refs[1];
      r.tokens   = 3'(tok_idx);
      wanted.push_back(r);
    endfunction

    function void note_byte(bit [7:0] b);
      if (!active) begin
        if (b == CH_START) begin
          active = 1;
          nbytes = 0;
          tok_idx = 0;
          in_tok = 0;
          conv_done = 0;
          neg = 0;
          sign_seen = 0;
          mag = 0;
          crc = CRC_INIT;
          text_end = 0;
        end
        return;
      end
      if (b == CH_END) begin
        if (nbytes == 0) active = 0;
        else close_frame();
        return;
      end
      nbytes++;
      text_char(b);
      if (nbytes >= MAX_FRAME_BYTES_DEF) close_frame();
    endfunction

    function void cmp(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(cmd_result_t got);
      cmd_result_t e;
      if (wanted.size() == 0) begin
        $error("result beat with no frame pending");
        errors++;
        return;
      end
      e = wanted.pop_front();
      cmp("speed_cmd", e.speed, got.speed);
      cmp("turn_cmd", e.turn, got.turn);
      cmp("sense_cmd", e.sense, got.sense);
      cmp("crc_received", e.crc_rx, got.crc_rx);
      cmp("crc_computed", {24'd0, e.crc_calc}, {24'd0, got.crc_calc});
      cmp("crc_ok", {31'd0, e.ok}, {31'd0, got.ok});
      cmp("left_ref", e.left, got.left);
      cmp("right_ref", e.right, got.right);
      cmp("token_total", {29'd0, e.tokens}, {29'd0, got.tokens});
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_BYTES = 300;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_speed_cmd, out_turn_cmd, out_sense_cmd, out_crc_received;
  logic [7:0]         out_crc_computed;
  logic               out_crc_ok;
  logic signed [23:0] out_left_ref, out_right_ref;
  logic [2:0]         out_token_total;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [7:0]         cfg_track_factor;

  cmd_frame_scoreboard sb;
  bit [7:0]    tx_q[$];
  int          bytes_sent;
  int          cycles;
  int          stall_left;
  bit          calm;
  cmd_result_t got_beat;

  ascii_command_frame_crc_checker_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_speed_cmd    (out_speed_cmd),
    .out_turn_cmd     (out_turn_cmd),
    .out_sense_cmd    (out_sense_cmd),
    .out_crc_received (out_crc_received),
    .out_crc_computed (out_crc_computed),
    .out_crc_ok       (out_crc_ok),
    .out_left_ref     (out_left_ref),
    .out_right_ref    (out_right_ref),
    .out_token_total  (out_token_total),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_track_factor (cfg_track_factor)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: check accepted beats, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_beat.speed    = out_speed_cmd;
      got_beat.turn     = out_turn_cmd;
      got_beat.sense    = out_sense_cmd;
      got_beat.crc_rx   = out_crc_received;
      got_beat.crc_calc = out_crc_computed;
      got_beat.ok       = out_crc_ok;
      got_beat.left     = out_left_ref;
      got_beat.right    = out_right_ref;
      got_beat.tokens   = out_token_total;
      sb.check_result(got_beat);
    end
    if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          out_stall  <= 1'b0;
          stall_left <= $urandom_range(1, 30);
        end
        9: begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(8, 25);
        end
        default: begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(0, 2);
        end
      endcase
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) tx_q.push_back(s[i]);
  endfunction

  function automatic string blanks(int lo, int hi);
    string s;
    s = "";
    repeat ($urandom_range(lo, hi)) s = {s, " "};
    return s;
  endfunction

  // one numeric token, sometimes with sign, leading whitespace or junk
  function automatic string num_text();
    int    v;
    string s, ws;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 400) - 200;
      4: begin
        case ($urandom_range(0, 7))
          0: v = 32767;
          1: v = -32768;
          2: v = 32768;
          3: v = -32769;
          4: v = 99999;
          5: v = -99999;
          6: v = 0;
          default: v = 65535;
        endcase
      end
      default: begin
        v = $urandom_range(0, 70000);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    s = $sformatf("%0d", v);
    ws = "x";
    ws.putc(0, 8'($urandom_range(9, 13)));
    case ($urandom_range(0, 11))
      0: if (v >= 0) s = {"+", s};
      1: s = {ws, s};
      2: s = {ws, ws, "-", s};
      3: s = {s, "k"};
      4: s = {"000", s};
      5: s = "1234567890123";
      6: s = "-";
      7: s = "+-4";
      default: ;
    endcase
    return s;
  endfunction

  function automatic void add_frame(string t1, string t2, string t3, int ntok, bit crc_good);
    string    norm, cs;
    bit [7:0] c;
    norm = {"$", t1};
    if (ntok > 1) norm = {norm, " ", t2};
    if (ntok > 2) norm = {norm, " ", t3};
    c = crc_text(norm);
    add_text({"$", blanks(0, 2), t1});
    if (ntok > 1) add_text({blanks(1, 3), t2});
    if (ntok > 2) add_text({blanks(1, 3), t3});
    if (ntok > 3) begin
      if (crc_good) begin
        cs = $sformatf("%0d", c);
        case ($urandom_range(0, 5))
          0: cs = {"+", cs};
          1: cs = {"0", cs};
          default: ;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0: cs = $sformatf("%0d", c ^ 8'($urandom_range(1, 255)));
          1: cs = $sformatf("%0d", int'(c) + 256);
          default: cs = $sformatf("-%0d", c);
        endcase
      end
      add_text({blanks(1, 2), cs});
    end
    if (ntok > 4) add_text({blanks(1, 2), num_text()});
    if ($urandom_range(0, 19) == 0) begin
      tx_q.push_back(CH_NUL);
      add_text(num_text());
    end
    add_text({blanks(0, 2), ";"});
  endfunction

  task automatic send_byte(input bit [7:0] b);
    int gap;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic flush_tx();
    while (tx_q.size() != 0) send_byte(tx_q.pop_front());
  endtask

  // close any open frame and wait until every result has come out
  task automatic drain();
    add_text(";");
    flush_tx();
    in_valid <= 1'b0;
    while (sb.wanted.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_factor(input bit [7:0] f);
    cfg_valid        <= 1'b1;
    cfg_track_factor <= f;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.factor = f;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    int r;
    bit [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      case ($urandom_range(0, 9))
        0: add_frame(num_text(), num_text(), num_text(), $urandom_range(1, 3), 1);
        1: add_frame(num_text(), num_text(), num_text(), 5, 1);
        2, 3: add_frame(num_text(), num_text(), num_text(), 4, 0);
        default: add_frame(num_text(), num_text(), num_text(), 4, 1);
      endcase
    end else if (r < 75) begin
      repeat ($urandom_range(1, 4)) begin
        b = 8'($urandom_range(0, 255));
        tx_q.push_back(b == CH_START ? CH_END : b);
      end
    end else if (r < 87) begin
      add_text("$");
      repeat ($urandom_range(0, 70)) tx_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) add_text(";");
    end else if (r < 94) begin
      // runs into the length cap; the trailing ';' lands while idle
      add_text("$");
      while (tx_q.size() < 70) add_text({num_text(), " "});
      add_text(";");
    end else begin
      case ($urandom_range(0, 2))
        0: add_text("$;");
        1: add_text("$  ;");
        default: add_text("$$7 1;");
      endcase
    end
    flush_tx();
  endtask

  initial begin
    int       p;
    bit [7:0] f;
    sb               = new();
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_rx_byte       = 8'd0;
    out_stall        = 1'b0;
    cfg_valid        = 1'b0;
    cfg_track_factor = 8'd0;
    cycles           = 0;
    stall_left       = 0;
    calm             = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle noise, empty frame, blank frame, extremes, '$' as data
    add_text("q$;$ ;");
    add_frame("-32768", "32767", "+0", 4, 1);
    add_frame("\t-99999", "99999", "5x", 4, 0);
    add_text("$$7;");
    flush_tx();

    for (p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: f = 8'd0;
        1: f = 8'd255;
        2: f = 8'd1;
        3: f = 8'($urandom_range(2, 254));
        4: f = TRACK_RESET;
        default: f = 8'd128;
      endcase
      write_factor(f);
      calm = (p == 3);
      while (bytes_sent < (p + 1) * PHASE_BYTES + 60) random_item();
    end
    drain();

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
